FILE: rtl/icmb_pkg.sv
// ----------------------------------------------------------------------------
// icmb_pkg
// Types, register codes and helper functions for the mirrored-border
// streaming convolution.
// ----------------------------------------------------------------------------
`default_nettype none

package icmb_pkg;

  typedef struct packed {
    logic [15:0] pixel_value;
    logic        drain;
  } pix_t;

  typedef struct packed {
    logic [15:0] filtered_value;
    logic        end_of_row;
    logic        end_of_frame;
  } res_t;

  localparam logic [2:0] REG_FRAME_WIDTH   = 3'd0;
  localparam logic [2:0] REG_FRAME_HEIGHT  = 3'd1;
  localparam logic [2:0] REG_KERNEL_RADIUS = 3'd2;
  localparam logic [2:0] REG_TAPS_ROW0     = 3'd3;
  localparam logic [2:0] REG_TAPS_ROW1     = 3'd4;
  localparam logic [2:0] REG_TAPS_ROW2     = 3'd5;
  localparam logic [2:0] REG_TAPS_ROW3     = 3'd6;
  localparam logic [2:0] REG_TAPS_ROW4     = 3'd7;

  localparam int          KSIZE      = 5;
  localparam int          TAP_W      = 12;
  localparam int          PIX_W      = 16;
  localparam logic [12:0] MAX_HEIGHT = 13'd4096;

  // floor(x/5) by reciprocal multiply, exact for x < 16384
  function automatic logic [10:0] div5(input logic [12:0] x);
    logic [26:0] p;
    p = 27'(x) * 27'd13108;
    return p[26:16];
  endfunction

  function automatic logic [2:0] mod5(input logic [12:0] x, input logic [10:0] q);
    logic [12:0] r;
    r = x - 13'(q) * 13'd5;
    return r[2:0];
  endfunction

  // mirror about both edges, then clamp for frames of size one
  function automatic logic [12:0] fold(input logic signed [14:0] x, input logic [12:0] m);
    logic signed [15:0] v;
    logic signed [15:0] ms;
    ms = $signed({3'b000, m});
    v  = {x[14], x};
    if (v < 16'sd0) v = -v - 16'sd1;
    else if (v >= ms) v = (ms <<< 1) - v - 16'sd1;
    if (v < 16'sd0) v = 16'sd0;
    if (v > ms - 16'sd1) v = ms - 16'sd1;
    return v[12:0];
  endfunction

endpackage

`default_nettype wire

FILE: rtl/icmb_ram.sv
// ----------------------------------------------------------------------------
// icmb_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module icmb_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 205
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: rtl/image_convolution_mirror_border.sv
// ----------------------------------------------------------------------------
// image_convolution_mirror_border
// Streaming 5x5 convolution with mirrored frame borders.
// ----------------------------------------------------------------------------
// Takes one pixel (or drain) transaction per clock while pix_stall is low
// and gives at most one result per transaction, |sum(tap * pixel)| >> 10
// saturated to 16 bits, once the result's window has arrived. The last
// five rows live in 25 RAM banks (row mod 5, column mod 5), so a whole
// window is read in parallel. A released result passes the RAM read,
// multiply, row sums, and total and output register stages; input stalls
// only when that pipeline is full and the output is stalled. Configuration
// is taken at any time with cfg_ready tied high and should change only
// between frames.
`default_nettype none

module image_convolution_mirror_border #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_RADIUS = 2
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           pix_valid,
  output logic                pix_stall,
  input  wire icmb_pkg::pix_t pix_data,
  output logic                res_valid,
  input  wire logic           res_stall,
  output icmb_pkg::res_t      res_data,
  input  wire logic           cfg_valid,
  output logic                cfg_ready,
  input  wire logic [2:0]     cfg_index,
  input  wire logic [59:0]    cfg_data
);
  import icmb_pkg::*;

  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int DEPTH = (MAX_WIDTH + 4) / 5;
  localparam int AW    = $clog2(DEPTH);

  // configuration
  logic [10:0] frame_width;
  logic [12:0] frame_height;
  logic [1:0]  kernel_radius;
  logic [59:0] taps_row [KSIZE];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width   <= 11'd1024;
      frame_height  <= 13'd768;
      kernel_radius <= 2'd1;
      taps_row[0]   <= '0;
      taps_row[1]   <= '0;
      taps_row[2]   <= 60'h4_0000_0000;
      taps_row[3]   <= '0;
      taps_row[4]   <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_FRAME_WIDTH:   frame_width   <= cfg_data[10:0];
        REG_FRAME_HEIGHT:  frame_height  <= cfg_data[12:0];
        REG_KERNEL_RADIUS: kernel_radius <= cfg_data[1:0];
        REG_TAPS_ROW0:     taps_row[0]   <= cfg_data;
        REG_TAPS_ROW1:     taps_row[1]   <= cfg_data;
        REG_TAPS_ROW2:     taps_row[2]   <= cfg_data;
        REG_TAPS_ROW3:     taps_row[3]   <= cfg_data;
        REG_TAPS_ROW4:     taps_row[4]   <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [12:0] weff, heff;
  logic [1:0]  reff;

  always_comb begin
    if (frame_width == 11'd0) weff = 13'd1;
    else if (13'(frame_width) > 13'(MAX_WIDTH)) weff = 13'(MAX_WIDTH);
    else weff = 13'(frame_width);
    if (frame_height == 13'd0) heff = 13'd1;
    else if (frame_height > MAX_HEIGHT) heff = MAX_HEIGHT;
    else heff = frame_height;
    if (kernel_radius > 2'(MAX_RADIUS)) reff = 2'(MAX_RADIUS);
    else reff = kernel_radius;
  end

  // taps outside the radius read as zero
  logic signed [TAP_W-1:0] tapm [KSIZE][KSIZE];

  always_comb begin
    for (int a = 0; a < KSIZE; a++) begin
      for (int b = 0; b < KSIZE; b++) begin
        if ((a >= 2 - int'(reff)) && (a <= 2 + int'(reff)) &&
            (b >= 2 - int'(reff)) && (b <= 2 + int'(reff)))
          tapm[a][b] = $signed(taps_row[a][TAP_W*b +: TAP_W]);
        else
          tapm[a][b] = '0;
      end
    end
  end

  // pipeline flow control
  logic v1, v2, v3, v4;
  logic load1, load2, load3, load4;
  logic acc;

  assign load4     = !v4 || !res_stall;
  assign load3     = !v3 || load4;
  assign load2     = !v2 || load3;
  assign load1     = !v1 || load2;
  assign pix_stall = !load1;
  assign acc       = pix_valid && !pix_stall;

  // position state
  logic [11:0]   in_row, out_row, in_row_next, out_row_next;
  logic [CW-1:0] in_col, out_col, in_col_next, out_col_next;
  logic [AW-1:0] in_col_q, in_col_q_next;
  logic [2:0]    in_col_m, in_col_m_next, in_row_m, in_row_m_next;
  logic          in_done, in_done_next;

  logic        pix_in, ready, eor, eof;
  logic [12:0] col_inc, row_inc, rr, cc;

  always_comb begin
    pix_in        = !pix_data.drain && !in_done;
    in_row_next   = in_row;
    in_col_next   = in_col;
    in_col_q_next = in_col_q;
    in_col_m_next = in_col_m;
    in_row_m_next = in_row_m;
    in_done_next  = in_done;
    col_inc       = 13'(in_col) + 13'd1;
    row_inc       = 13'(in_row) + 13'd1;
    if (pix_in) begin
      if (col_inc >= weff) begin
        in_col_next   = '0;
        in_col_q_next = '0;
        in_col_m_next = '0;
        if (row_inc >= heff) begin
          in_row_next   = '0;
          in_row_m_next = '0;
          in_done_next  = 1'b1;
        end else begin
          in_row_next   = row_inc[11:0];
          in_row_m_next = (in_row_m == 3'd4) ? 3'd0 : in_row_m + 3'd1;
        end
      end else begin
        in_col_next   = col_inc[CW-1:0];
        in_col_m_next = (in_col_m == 3'd4) ? 3'd0 : in_col_m + 3'd1;
        in_col_q_next = (in_col_m == 3'd4) ? in_col_q + AW'(1) : in_col_q;
      end
    end

    rr = 13'(out_row) + 13'(reff);
    if (rr > heff - 13'd1) rr = heff - 13'd1;
    cc = 13'(out_col) + 13'(reff);
    if (cc > weff - 13'd1) cc = weff - 13'd1;
    ready = in_done_next || (13'(in_row_next) > rr) ||
            ((13'(in_row_next) == rr) && (13'(in_col_next) > cc));

    eor = 13'(out_col) >= weff - 13'd1;
    eof = eor && (13'(out_row) >= heff - 13'd1);

    out_row_next = out_row;
    out_col_next = out_col;
    if (ready) begin
      if (eof) begin
        in_row_next   = '0;
        in_col_next   = '0;
        in_col_q_next = '0;
        in_col_m_next = '0;
        in_row_m_next = '0;
        in_done_next  = 1'b0;
        out_row_next  = '0;
        out_col_next  = '0;
      end else if (eor) begin
        out_col_next = '0;
        out_row_next = out_row + 12'd1;
      end else begin
        out_col_next = out_col + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_row   <= '0;
      in_col   <= '0;
      in_col_q <= '0;
      in_col_m <= '0;
      in_row_m <= '0;
      in_done  <= 1'b0;
      out_row  <= '0;
      out_col  <= '0;
    end else if (acc) begin
      in_row   <= in_row_next;
      in_col   <= in_col_next;
      in_col_q <= in_col_q_next;
      in_col_m <= in_col_m_next;
      in_row_m <= in_row_m_next;
      in_done  <= in_done_next;
      out_row  <= out_row_next;
      out_col  <= out_col_next;
    end
  end

  // window addressing: bank row = row mod 5, bank column = col mod 5
  logic [2:0]    rsl [KSIZE];
  logic [2:0]    csl [KSIZE];
  logic [AW-1:0] cq  [KSIZE];
  logic [AW-1:0] raddr [KSIZE];

  always_comb begin
    logic [12:0] fr, fc;
    logic [10:0] qr, qc;
    for (int a = 0; a < KSIZE; a++) begin
      fr     = fold($signed(15'(out_row)) + 15'sd2 - 15'(a), heff);
      qr     = div5(fr);
      rsl[a] = mod5(fr, qr);
      fc     = fold($signed(15'(out_col)) + 15'sd2 - 15'(a), weff);
      qc     = div5(fc);
      csl[a] = mod5(fc, qc);
      cq[a]  = qc[AW-1:0];
    end
    for (int s = 0; s < KSIZE; s++) begin
      raddr[s] = '0;
      for (int b = 0; b < KSIZE; b++) begin
        if (csl[b] == 3'(s)) raddr[s] = cq[b];
      end
    end
  end

  logic wr_en;
  assign wr_en = acc && pix_in;

  logic [PIX_W-1:0] bank_q [KSIZE][KSIZE];

  for (genvar rs = 0; rs < KSIZE; rs++) begin : g_row
    for (genvar cs = 0; cs < KSIZE; cs++) begin : g_col
      icmb_ram #(.WIDTH(PIX_W), .DEPTH(DEPTH)) u_bank (
        .clk   (clk),
        .we    (wr_en && (in_row_m == 3'(rs)) && (in_col_m == 3'(cs))),
        .waddr (in_col_q),
        .wdata (pix_data.pixel_value),
        .re    (load1),
        .raddr (raddr[cs]),
        .rdata (bank_q[rs][cs])
      );
    end
  end

  // stage 1: RAM output plus forwarding of a same-cycle write
  logic             eor1, eof1;
  logic [2:0]       rsl1 [KSIZE];
  logic [2:0]       csl1 [KSIZE];
  logic [AW-1:0]    raddr1 [KSIZE];
  logic             byp_en;
  logic [2:0]       byp_rs, byp_cs;
  logic [AW-1:0]    byp_addr;
  logic [PIX_W-1:0] byp_data;

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (load1) v1 <= acc && ready;
  end

  always_ff @(posedge clk) begin
    if (load1) begin
      eor1     <= eor;
      eof1     <= eof;
      rsl1     <= rsl;
      csl1     <= csl;
      raddr1   <= raddr;
      byp_en   <= wr_en;
      byp_rs   <= in_row_m;
      byp_cs   <= in_col_m;
      byp_addr <= in_col_q;
      byp_data <= pix_data.pixel_value;
    end
  end

  logic [PIX_W-1:0] bd [KSIZE][KSIZE];

  always_comb begin
    for (int rs = 0; rs < KSIZE; rs++) begin
      for (int cs = 0; cs < KSIZE; cs++) begin
        if (byp_en && (byp_rs == 3'(rs)) && (byp_cs == 3'(cs)) &&
            (byp_addr == raddr1[cs]))
          bd[rs][cs] = byp_data;
        else
          bd[rs][cs] = bank_q[rs][cs];
      end
    end
  end

  // stage 2: products
  logic signed [28:0] prod2 [KSIZE][KSIZE];
  logic               eor2, eof2;

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (load2) v2 <= v1;
  end

  always_ff @(posedge clk) begin
    if (load2) begin
      eor2 <= eor1;
      eof2 <= eof1;
      for (int a = 0; a < KSIZE; a++) begin
        for (int b = 0; b < KSIZE; b++) begin
          // a zero tap drops its pixel, which may not be written yet
          if (tapm[a][b] == '0)
            prod2[a][b] <= '0;
          else
            prod2[a][b] <= $signed({1'b0, bd[rsl1[a]][csl1[b]]}) * tapm[a][b];
        end
      end
    end
  end

  // stage 3: row sums
  logic signed [31:0] rsum3 [KSIZE];
  logic               eor3, eof3;

  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else if (load3) v3 <= v2;
  end

  always_ff @(posedge clk) begin
    logic signed [31:0] s;
    if (load3) begin
      eor3 <= eor2;
      eof3 <= eof2;
      for (int a = 0; a < KSIZE; a++) begin
        s = '0;
        for (int b = 0; b < KSIZE; b++) s = s + 32'(prod2[a][b]);
        rsum3[a] <= s;
      end
    end
  end

  // stage 4: total, magnitude, truncate, saturate
  logic signed [34:0] tot;
  logic        [34:0] mag, shr;
  logic [PIX_W-1:0]   sat;

  always_comb begin
    tot = '0;
    for (int a = 0; a < KSIZE; a++) tot = tot + 35'(rsum3[a]);
    mag = (tot < 0) ? 35'(-tot) : 35'(tot);
    shr = mag >> 10;
    sat = (shr > 35'd65535) ? 16'hFFFF : shr[15:0];
  end

  logic [PIX_W-1:0] filt4;
  logic             eor4, eof4;

  always_ff @(posedge clk) begin
    if (rst) v4 <= 1'b0;
    else if (load4) v4 <= v3;
  end

  always_ff @(posedge clk) begin
    if (load4) begin
      filt4 <= sat;
      eor4  <= eor3;
      eof4  <= eof3;
    end
  end

  assign res_valid               = v4;
  assign res_data.filtered_value = filt4;
  assign res_data.end_of_row     = eor4;
  assign res_data.end_of_frame   = eof4;

endmodule

`default_nettype wire

FILE: test/tb_image_convolution_mirror_border.sv
// ----------------------------------------------------------------------------
// tb_image_convolution_mirror_border
// Self-checking bench for the mirrored-border streaming convolution.
// ----------------------------------------------------------------------------
// Frames of random or constant pixels run under several sizes, radii and
// kernels. Each accepted transaction is run through a local model of the
// window logic, and the result stream is compared against it in order.
`timescale 1ns / 100ps
`default_nettype none

module tb_image_convolution_mirror_border;
  import icmb_pkg::*;

  localparam int MAXW = 1024;
  localparam int RING = 5 * MAXW;
  localparam int CYCLE_LIMIT = 2000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic pix_valid = 1'b0;
  logic pix_stall;
  pix_t pix_data = '0;
  logic res_valid;
  logic res_stall = 1'b0;
  res_t res_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [59:0] cfg_data = '0;

  image_convolution_mirror_border uut (
    .clk(clk), .rst(rst),
    .pix_valid(pix_valid), .pix_stall(pix_stall), .pix_data(pix_data),
    .res_valid(res_valid), .res_stall(res_stall), .res_data(res_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // predictor state
  logic [10:0] m_width;
  logic [12:0] m_height;
  logic [1:0] m_radius;
  logic [59:0] m_taps [5];
  logic [15:0] m_ring [RING];
  int unsigned m_in_row, m_in_col, m_out_row, m_out_col;
  bit m_in_done;

  res_t expected_results [$];
  pix_t pending_pixels [$];
  int error_count = 0;
  int cycle_count = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_cycles = 0;
  bit finished = 1'b0;
  bit in_taken = 1'b0;

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic int unsigned width_eff();
    if (m_width == 0) return 1;
    if (m_width > MAXW) return MAXW;
    return m_width;
  endfunction

  function automatic int unsigned height_eff();
    if (m_height == 0) return 1;
    if (m_height > 4096) return 4096;
    return m_height;
  endfunction

  function automatic int radius_eff();
    return (m_radius > 2) ? 2 : int'(m_radius);
  endfunction

  function automatic int mirror_index(int x, int m);
    if (x < 0) x = -x - 1;
    else if (x >= m) x = 2 * m - x - 1;
    if (x < 0) x = 0;
    if (x > m - 1) x = m - 1;
    return x;
  endfunction

  function automatic logic [15:0] window_sum(int r, int c);
    int w, h, rad, x1, y1;
    longint acc;
    longint unsigned mag;
    logic signed [11:0] tap;
    w = width_eff();
    h = height_eff();
    rad = radius_eff();
    acc = 0;
    for (int j = -rad; j <= rad; j++)
      for (int k = -rad; k <= rad; k++) begin
        x1 = mirror_index(r - j, h);
        y1 = mirror_index(c - k, w);
        tap = m_taps[j + 2][12 * (k + 2) +: 12];
        acc += longint'(tap) * longint'(m_ring[(x1 * w + y1) % RING]);
      end
    mag = (acc < 0) ? -acc : acc;
    mag = mag >> 10;
    if (mag > 65535) mag = 65535;
    return mag[15:0];
  endfunction

  task automatic predict_pixel(input pix_t p);
    int unsigned w, h, rad, rr, cc;
    res_t r;
    w = width_eff();
    h = height_eff();
    rad = radius_eff();
    if (!p.drain && !m_in_done) begin
      m_ring[(m_in_row * w + m_in_col) % RING] = p.pixel_value;
      m_in_col++;
      if (m_in_col >= w) begin
        m_in_col = 0;
        m_in_row++;
        if (m_in_row >= h) begin
          m_in_row = 0;
          m_in_done = 1'b1;
        end
      end
    end
    if (!m_in_done) begin
      rr = m_out_row + rad;
      if (rr > h - 1) rr = h - 1;
      cc = m_out_col + rad;
      if (cc > w - 1) cc = w - 1;
      if (m_in_row * w + m_in_col <= rr * w + cc) return;
    end
    r.end_of_row = (m_out_col >= w - 1);
    r.end_of_frame = r.end_of_row && (m_out_row >= h - 1);
    r.filtered_value = window_sum(m_out_row, m_out_col);
    expected_results = {expected_results, r};
    if (r.end_of_frame) begin
      m_in_row = 0; m_in_col = 0; m_out_row = 0; m_out_col = 0;
      m_in_done = 1'b0;
    end else if (r.end_of_row) begin
      m_out_col = 0;
      m_out_row++;
    end else begin
      m_out_col++;
    end
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch %s: got %0h expected %0h", what, got, want);
    error_count++;
  endtask

  // driver
  always @(negedge clk) begin
    if (!rst) begin
      if (!pix_valid || in_taken) begin
        if (pending_pixels.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          pix_data <= pending_pixels.pop_front();
          pix_valid <= 1'b1;
        end else begin
          pix_valid <= 1'b0;
        end
      end
      if (hold_cycles > 0) res_stall <= 1'b1;
      else res_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(negedge clk) begin
    if (hold_cycles > 0) hold_cycles <= hold_cycles - 1;
  end

  // monitor
  always @(posedge clk) begin
    in_taken <= pix_valid && !pix_stall;
    if (!rst) begin
      cycle_count <= cycle_count + 1;
      if (pix_valid && !pix_stall) predict_pixel(pix_data);
      if (res_valid && !res_stall) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected transaction", int'(res_data), 0);
        end else begin
          res_t e;
          e = expected_results.pop_front();
          if (res_data.filtered_value !== e.filtered_value)
            report_mismatch("filtered_value", int'(res_data.filtered_value),
                            int'(e.filtered_value));
          if (res_data.end_of_row !== e.end_of_row)
            report_mismatch("end_of_row", int'(res_data.end_of_row), int'(e.end_of_row));
          if (res_data.end_of_frame !== e.end_of_frame)
            report_mismatch("end_of_frame", int'(res_data.end_of_frame),
                            int'(e.end_of_frame));
        end
      end
      if (cycle_count > CYCLE_LIMIT && !finished) begin
        $display("timeout");
        $display("tb_image_convolution_mirror_border: errors");
        $finish;
      end
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [59:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_FRAME_WIDTH: m_width = val[10:0];
      REG_FRAME_HEIGHT: m_height = val[12:0];
      REG_KERNEL_RADIUS: m_radius = val[1:0];
      default: m_taps[idx - REG_TAPS_ROW0] = val;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_pixels.size() > 0 || pix_valid || expected_results.size() > 0)
      @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  function automatic logic [59:0] random_taps();
    logic [59:0] t;
    t = 60'({$urandom, $urandom});
    // keep most taps small so sums stay below saturation
    for (int c = 0; c < 5; c++)
      if ($urandom_range(3) != 0) t[12 * c +: 12] = 12'($signed($urandom_range(512)) - 256);
    return t;
  endfunction

  // one frame's pixels plus enough drain transactions to flush it
  task automatic queue_frame(input int w, input int h, input int mode);
    pix_t p;
    for (int i = 0; i < w * h; i++) begin
      p.drain = ($urandom_range(19) == 0);
      case (mode)
        0: p.pixel_value = 16'($urandom);
        1: p.pixel_value = 16'hFFFF;
        default: p.pixel_value = 16'h0000;
      endcase
      pending_pixels = {pending_pixels, p};
      if (p.drain) i--;
    end
    for (int i = 0; i < 3 * w + 8; i++) begin
      p.drain = 1'b1;
      p.pixel_value = 16'($urandom);
      pending_pixels = {pending_pixels, p};
    end
  endtask

  task automatic set_shape(input int w, input int h, input int rad);
    write_reg(REG_FRAME_WIDTH, 60'(w));
    write_reg(REG_FRAME_HEIGHT, 60'(h));
    write_reg(REG_KERNEL_RADIUS, 60'(rad));
  endtask

  initial begin
    int w, h;
    m_width = 11'd1024;
    m_height = 13'd768;
    m_radius = 2'd1;
    foreach (m_taps[i]) m_taps[i] = '0;
    m_taps[2] = 60'h400000000;
    foreach (m_ring[i]) m_ring[i] = '0;
    m_in_row = 0; m_in_col = 0; m_out_row = 0; m_out_col = 0;
    m_in_done = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: identity kernel, tiny frames, extremes
    set_shape(1, 1, 0);
    queue_frame(1, 1, 1);
    wait_drained();
    set_shape(2, 3, 2);
    for (int r = 0; r < 5; r++) write_reg(3'(REG_TAPS_ROW0 + r), {60{1'b1}});
    queue_frame(2, 3, 1);
    wait_drained();
    for (int r = 0; r < 5; r++) write_reg(3'(REG_TAPS_ROW0 + r), {5{12'h7FF}});
    set_shape(3, 2, 3);
    queue_frame(3, 2, 1);
    wait_drained();
    for (int r = 0; r < 5; r++) write_reg(3'(REG_TAPS_ROW0 + r), {5{12'h800}});
    set_shape(0, 0, 1);
    queue_frame(1, 1, 2);
    wait_drained();

    // random frames under three idle schemes
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 26 : (phase == 1) ? 87 : 0;
      recv_idle_pct = (phase == 0) ? 87 : (phase == 1) ? 26 : 0;
      for (int f = 0; f < 4; f++) begin
        w = $urandom_range(1, 8);
        h = $urandom_range(1, 6);
        // a full-size frame so the long hold backs up into the input
        if (phase == 1 && f == 2) begin
          w = 8;
          h = 6;
        end
        set_shape(w, h, $urandom_range(0, 3));
        for (int r = 0; r < 5; r++) write_reg(3'(REG_TAPS_ROW0 + r), random_taps());
        if (phase == 1 && f == 2) hold_cycles = 300;
        queue_frame(w, h, 0);
        wait_drained();
      end
    end
    set_shape(1024, 4096, 2);
    set_shape(1, 1, 1);
    wait_drained();
    finished = 1'b1;
    if (error_count == 0) $display("tb_image_convolution_mirror_border: clean");
    else $display("tb_image_convolution_mirror_border: errors");
    $finish;
  end

endmodule

`default_nettype wire

FILE: sim.f
rtl/icmb_pkg.sv
rtl/icmb_ram.sv
rtl/image_convolution_mirror_border.sv
test/tb_image_convolution_mirror_border.sv
